// ===== rtl/rcpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpt_pkg
// Sizes, field widths and shared types of the row/column permutation table.
// ----------------------------------------------------------------------------
package rcpt_pkg;

  localparam int ROWS = 1024;
  localparam int COLS = 4096;

  // item field widths
  localparam int IDX_W     = 13;
  localparam int VALUE_W   = 23;
  localparam int ANS_ROW_W = 11;
  localparam int ANS_COL_W = 13;

  // table address and entry widths
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_AW = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int ROW_VW = $clog2(ROWS + 1);
  localparam int COL_VW = $clog2(COLS + 1);

  // clearing sweep
  localparam int MAX_DEPTH = (ROWS > COLS) ? ROWS : COLS;
  localparam int CLR_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  // divider remainder and value arithmetic
  localparam int REM_W  = COL_AW + ROW_AW + 1;
  localparam int CALC_W = ROW_VW + COL_VW + 1;

  typedef enum logic [1:0] {
    REQ_SWAP_ROWS = 2'd0,
    REQ_SWAP_COLS = 2'd1,
    REQ_VALUE     = 2'd2,
    REQ_POSITION  = 2'd3
  } req_type_t;

  typedef struct packed {
    logic busy;
    logic last;
  } div_stat_t;

endpackage

// ===== rtl/rcpt_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpt_req_if
// Request channel: swap, value query or position query, valid/ready.
// ----------------------------------------------------------------------------
interface rcpt_req_if;
  import rcpt_pkg::*;

  logic               valid;
  logic               ready;
  req_type_t          req_type;
  logic [IDX_W-1:0]   first_index;
  logic [IDX_W-1:0]   second_index;
  logic [VALUE_W-1:0] cell_value;

  modport source (
    output valid, req_type, first_index, second_index, cell_value,
    input  ready
  );

  modport sink (
    input  valid, req_type, first_index, second_index, cell_value,
    output ready
  );

endinterface

// ===== rtl/rcpt_ans_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpt_ans_if
// Answer channel: query answers and range errors, valid/ready.
// ----------------------------------------------------------------------------
interface rcpt_ans_if;
  import rcpt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [VALUE_W-1:0]   answer_value;
  logic [ANS_ROW_W-1:0] answer_row;
  logic [ANS_COL_W-1:0] answer_col;
  logic                 range_error;

  modport source (
    output valid, answer_value, answer_row, answer_col, range_error,
    input  ready
  );

  modport sink (
    input  valid, answer_value, answer_row, answer_col, range_error,
    output ready
  );

endinterface

// ===== rtl/row_col_permutation_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_col_permutation_table
// Row/column swap tracker with forward and inverse permutation tables.
// ----------------------------------------------------------------------------
// Requests arrive on req (valid/ready), answers leave on ans (valid/ready).
// A row or column swap updates the origin and place tables of its axis and
// gives no answer; a value query or position query gives one answer item;
// a request with an index or value out of range gives one item with
// range_error set and changes nothing.
// Steps per item, from acceptance to the next acceptance:
//   swap            read both origins, then write states S_WR1 and S_WR2
//   value query     origin read, then answer
//   position query  offset split into row and column, place reads,
//                   then answer
//   range error     answer with range_error set
// After reset the block sweeps all tables back to identity, one entry per
// cycle over max(ROWS, COLS) = 4096 entries, with req.ready low.
// Answers sit in an output register; while the receiver stalls a finished
// answer waits there and the next request is still taken, stalling only
// when a second answer is ready before the first has left.
// ----------------------------------------------------------------------------
module row_col_permutation_table (
  input logic       clk,
  input logic       rst,
  rcpt_req_if.sink  req,
  rcpt_ans_if.source ans
);
  import rcpt_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WR1,
    S_WR2,
    S_DIV,
    S_PREAD,
    S_RESULT
  } state_t;

  state_t               state;
  logic [CLR_W-1:0]     clr;
  logic [CLR_W:0]       clr_ext;
  req_type_t            typ;
  logic [IDX_W-1:0]     a_idx;
  logic [IDX_W-1:0]     b_idx;
  logic                 err;

  logic                 ans_valid;
  logic [VALUE_W-1:0]   ans_value;
  logic [ANS_ROW_W-1:0] ans_row;
  logic [ANS_COL_W-1:0] ans_col;
  logic                 ans_error;

  logic                 accept;
  logic                 in_err;
  logic                 out_free;

  // divider
  div_stat_t            div_st;
  logic [ROW_AW-1:0]    div_quot;
  logic [REM_W-1:0]     div_rem;
  logic [REM_W-1:0]     div_dividend;

  // table ports
  logic                 ro_we, rp_we, co_we, cp_we;
  logic [ROW_AW-1:0]    ro_waddr, rp_waddr;
  logic [ROW_VW-1:0]    ro_wdata, rp_wdata;
  logic [COL_AW-1:0]    co_waddr, cp_waddr;
  logic [COL_VW-1:0]    co_wdata, cp_wdata;
  logic [ROW_AW-1:0]    ro0_raddr, ro1_raddr;
  logic [COL_AW-1:0]    co0_raddr, co1_raddr;
  logic [IDX_W-1:0]     co0_idx;
  logic [ROW_VW-1:0]    ro0_q, ro1_q, rp_q;
  logic [COL_VW-1:0]    co0_q, co1_q, cp_q;
  logic                 place_re;

  logic [CALC_W-1:0]    value_full;

  assign accept   = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign out_free = !ans_valid || ans.ready;

  assign ans.valid        = ans_valid;
  assign ans.answer_value = ans_value;
  assign ans.answer_row   = ans_row;
  assign ans.answer_col   = ans_col;
  assign ans.range_error  = ans_error;

  rcpt_check u_check (
    .req_type     (req.req_type),
    .first_index  (req.first_index),
    .second_index (req.second_index),
    .cell_value   (req.cell_value),
    .err          (in_err)
  );

  assign div_dividend = REM_W'(req.cell_value - VALUE_W'(1));

  rcpt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && (req.req_type == REQ_POSITION) && !in_err),
    .dividend (div_dividend),
    .stat     (div_st),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // origin reads are issued straight from the request at acceptance
  assign co0_idx   = (req.req_type == REQ_VALUE) ? req.second_index : req.first_index;
  assign ro0_raddr = ROW_AW'(req.first_index - IDX_W'(1));
  assign ro1_raddr = ROW_AW'(req.second_index - IDX_W'(1));
  assign co0_raddr = COL_AW'(co0_idx - IDX_W'(1));
  assign co1_raddr = COL_AW'(req.second_index - IDX_W'(1));
  assign place_re  = (state == S_PREAD);

  // origin tables are duplicated to read both swap partners at once
  rcpt_ram #(.DEPTH(ROWS), .WIDTH(ROW_VW)) u_row_origin0 (
    .clk (clk), .we (ro_we), .waddr (ro_waddr), .wdata (ro_wdata),
    .re (accept), .raddr (ro0_raddr), .rdata (ro0_q)
  );

  rcpt_ram #(.DEPTH(ROWS), .WIDTH(ROW_VW)) u_row_origin1 (
    .clk (clk), .we (ro_we), .waddr (ro_waddr), .wdata (ro_wdata),
    .re (accept), .raddr (ro1_raddr), .rdata (ro1_q)
  );

  rcpt_ram #(.DEPTH(COLS), .WIDTH(COL_VW)) u_col_origin0 (
    .clk (clk), .we (co_we), .waddr (co_waddr), .wdata (co_wdata),
    .re (accept), .raddr (co0_raddr), .rdata (co0_q)
  );

  rcpt_ram #(.DEPTH(COLS), .WIDTH(COL_VW)) u_col_origin1 (
    .clk (clk), .we (co_we), .waddr (co_waddr), .wdata (co_wdata),
    .re (accept), .raddr (co1_raddr), .rdata (co1_q)
  );

  rcpt_ram #(.DEPTH(ROWS), .WIDTH(ROW_VW)) u_row_place (
    .clk (clk), .we (rp_we), .waddr (rp_waddr), .wdata (rp_wdata),
    .re (place_re), .raddr (div_quot), .rdata (rp_q)
  );

  rcpt_ram #(.DEPTH(COLS), .WIDTH(COL_VW)) u_col_place (
    .clk (clk), .we (cp_we), .waddr (cp_waddr), .wdata (cp_wdata),
    .re (place_re), .raddr (COL_AW'(div_rem)), .rdata (cp_q)
  );

  assign clr_ext = {1'b0, clr};

  // write side: identity sweep, then the two halves of a swap
  always_comb begin
    ro_we    = 1'b0;
    rp_we    = 1'b0;
    co_we    = 1'b0;
    cp_we    = 1'b0;
    ro_waddr = ROW_AW'(clr);
    rp_waddr = ROW_AW'(clr);
    co_waddr = COL_AW'(clr);
    cp_waddr = COL_AW'(clr);
    ro_wdata = ROW_VW'(clr_ext + 1'b1);
    rp_wdata = ROW_VW'(clr_ext + 1'b1);
    co_wdata = COL_VW'(clr_ext + 1'b1);
    cp_wdata = COL_VW'(clr_ext + 1'b1);
    case (state)
      S_CLEAR: begin
        ro_we = (clr_ext < (CLR_W + 1)'(ROWS));
        rp_we = ro_we;
        co_we = (clr_ext < (CLR_W + 1)'(COLS));
        cp_we = co_we;
      end
      S_WR1: begin
        ro_we    = (typ == REQ_SWAP_ROWS);
        rp_we    = ro_we;
        co_we    = (typ == REQ_SWAP_COLS);
        cp_we    = co_we;
        ro_waddr = ROW_AW'(a_idx - IDX_W'(1));
        ro_wdata = ro1_q;
        rp_waddr = ROW_AW'(ro0_q - ROW_VW'(1));
        rp_wdata = ROW_VW'(b_idx);
        co_waddr = COL_AW'(a_idx - IDX_W'(1));
        co_wdata = co1_q;
        cp_waddr = COL_AW'(co0_q - COL_VW'(1));
        cp_wdata = COL_VW'(b_idx);
      end
      S_WR2: begin
        ro_we    = (typ == REQ_SWAP_ROWS);
        rp_we    = ro_we;
        co_we    = (typ == REQ_SWAP_COLS);
        cp_we    = co_we;
        ro_waddr = ROW_AW'(b_idx - IDX_W'(1));
        ro_wdata = ro0_q;
        rp_waddr = ROW_AW'(ro1_q - ROW_VW'(1));
        rp_wdata = ROW_VW'(a_idx);
        co_waddr = COL_AW'(b_idx - IDX_W'(1));
        co_wdata = co0_q;
        cp_waddr = COL_AW'(co1_q - COL_VW'(1));
        cp_wdata = COL_VW'(a_idx);
      end
      default: begin
        ro_we = 1'b0;
      end
    endcase
  end

  // original number of the cell now at (row, col)
  assign value_full = (CALC_W'(ro0_q) - CALC_W'(1)) * CALC_W'(COLS) + CALC_W'(co0_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      ans_valid <= 1'b0;
    end else begin
      if (ans_valid && ans.ready && (state != S_RESULT)) begin
        ans_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == CLR_W'(MAX_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            typ   <= req.req_type;
            a_idx <= req.first_index;
            b_idx <= req.second_index;
            err   <= in_err;
            if (in_err) begin
              state <= S_RESULT;
            end else begin
              case (req.req_type)
                REQ_SWAP_ROWS: state <= S_WR1;
                REQ_SWAP_COLS: state <= S_WR1;
                REQ_VALUE:     state <= S_RESULT;
                REQ_POSITION:  state <= S_DIV;
                default:       state <= S_IDLE;
              endcase
            end
          end
        end
        S_WR1: begin
          state <= S_WR2;
        end
        S_WR2: begin
          state <= S_IDLE;
        end
        S_DIV: begin
          if (div_st.last) begin
            state <= S_PREAD;
          end
        end
        S_PREAD: begin
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (out_free) begin
            ans_valid <= 1'b1;
            ans_error <= err;
            ans_value <= (!err && (typ == REQ_VALUE)) ? VALUE_W'(value_full) : '0;
            ans_row   <= (!err && (typ == REQ_POSITION)) ? ANS_ROW_W'(rp_q) : '0;
            ans_col   <= (!err && (typ == REQ_POSITION)) ? ANS_COL_W'(cp_q) : '0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // an in-range swap passes through S_WR1 and S_WR2 and is back to ready
  a_swap_turnaround : assert property (@(posedge clk) disable iff (rst)
    (accept && !in_err &&
     (req.req_type == REQ_SWAP_ROWS || req.req_type == REQ_SWAP_COLS))
    |-> ##3 req.ready)
    else $error("swap did not return to ready in three cycles");

  a_div_in_state : assert property (@(posedge clk) disable iff (rst)
    div_st.last |-> state == S_DIV)
    else $error("divider finished outside the divide state");

  a_ans_source : assert property (@(posedge clk) disable iff (rst)
    $rose(ans_valid) |-> $past(state) == S_RESULT)
    else $error("answer item raised outside the result state");

  a_error_zero : assert property (@(posedge clk) disable iff (rst)
    (ans_valid && ans_error) |->
    (ans_value == '0 && ans_row == '0 && ans_col == '0))
    else $error("range error item carries non-zero fields");

endmodule

// ===== rtl/rcpt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpt_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rcpt_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 11,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/rcpt_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpt_check
// Range check of an incoming request against the grid size.
// ----------------------------------------------------------------------------
module rcpt_check (
  input  rcpt_pkg::req_type_t          req_type,
  input  logic [rcpt_pkg::IDX_W-1:0]   first_index,
  input  logic [rcpt_pkg::IDX_W-1:0]   second_index,
  input  logic [rcpt_pkg::VALUE_W-1:0] cell_value,
  output logic                         err
);
  import rcpt_pkg::*;

  localparam int ICMP_W = IDX_W + 2;
  localparam int ZCMP_W = ROW_AW + COL_AW + VALUE_W;
  localparam logic [ICMP_W-1:0] ROWS_C  = ICMP_W'(ROWS);
  localparam logic [ICMP_W-1:0] COLS_C  = ICMP_W'(COLS);
  localparam logic [ZCMP_W-1:0] CELLS_C = ZCMP_W'(ROWS * COLS);

  logic a_row_ok, b_row_ok, a_col_ok, b_col_ok, z_ok;

  assign a_row_ok = (first_index != '0) && (ICMP_W'(first_index) <= ROWS_C);
  assign b_row_ok = (second_index != '0) && (ICMP_W'(second_index) <= ROWS_C);
  assign a_col_ok = (first_index != '0) && (ICMP_W'(first_index) <= COLS_C);
  assign b_col_ok = (second_index != '0) && (ICMP_W'(second_index) <= COLS_C);
  assign z_ok     = (cell_value != '0) && (ZCMP_W'(cell_value) <= CELLS_C);

  always_comb begin
    case (req_type)
      REQ_SWAP_ROWS: err = !(a_row_ok && b_row_ok);
      REQ_SWAP_COLS: err = !(a_col_ok && b_col_ok);
      REQ_VALUE:     err = !(a_row_ok && b_col_ok);
      REQ_POSITION:  err = !z_ok;
      default:       err = 1'b1;
    endcase
  end

endmodule

// ===== rtl/rcpt_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpt_div
// Splits a cell offset into row and column by COLS, registered in one step;
// COLS is a power of two, so the split is a shift and a mask.
// ----------------------------------------------------------------------------
module rcpt_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rcpt_pkg::REM_W-1:0]  dividend,
  output rcpt_pkg::div_stat_t         stat,
  output logic [rcpt_pkg::ROW_AW-1:0] quot,
  output logic [rcpt_pkg::REM_W-1:0]  rem
);
  import rcpt_pkg::*;

  logic busy;

  assign stat.busy = busy;
  assign stat.last = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= start;
      if (start) begin
        quot <= ROW_AW'(dividend / REM_W'(COLS));
        rem  <= dividend % REM_W'(COLS);
      end
    end
  end

  // an in-range offset gives a row below ROWS and a column below COLS
  a_rem_bound : assert property (@(posedge clk) disable iff (rst)
    stat.last |-> rem < REM_W'(COLS))
    else $error("remainder not below COLS after division");

  a_quot_bound : assert property (@(posedge clk) disable iff (rst)
    stat.last |-> (ROW_AW + 1)'(quot) < (ROW_AW + 1)'(ROWS))
    else $error("quotient not below ROWS after division");

  a_start_idle : assert property (@(posedge clk) disable iff (rst)
    start |=> busy)
    else $error("divider did not start");

  a_single_step : assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("divider busy for more than one cycle");

endmodule
